// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared constants of the priority scheduler
// Widths, event codes and command codes used by the cell and the core.
// ----------------------------------------------------------------------------
`default_nettype none
package pps_pkg;
	localparam int MAX_TASKS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;
	localparam int ID_W = 8;
	localparam int PRIO_W = 8;
	localparam int ORD_W = 8;
	localparam int FIELD_W = 16;
	localparam int EV_W = 3;

	localparam logic [EV_W-1:0] EV_ACCEPT = 3'd0;
	localparam logic [EV_W-1:0] EV_REJECT = 3'd1;
	localparam logic [EV_W-1:0] EV_IDLE = 3'd2;
	localparam logic [EV_W-1:0] EV_RAN = 3'd3;
	localparam logic [EV_W-1:0] EV_DONE = 3'd4;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_TICK = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/pps_cell.sv =====
// ----------------------------------------------------------------------------
// pps_cell: one task slot of the scheduler chain
// Holds one task; on a scan it compares itself with the running best candidate
// handed in by the core (the best of the cells scanned before) and passes the winner on.
// ----------------------------------------------------------------------------
`default_nettype none
module pps_cell #(
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
	parameter int IDX_W = 4
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [IDX_W-1:0]              my_idx,
	// write of a new task
	input  wire                          wr_en,
	input  wire [pps_pkg::ID_W-1:0]      wr_id,
	input  wire [TIME_BITS-1:0]          wr_arr,
	input  wire [pps_pkg::FIELD_W-1:0]   wr_len,
	input  wire [pps_pkg::PRIO_W-1:0]    wr_prio,
	input  wire [pps_pkg::ORD_W-1:0]     wr_ord,
	// scan step: release check and compare
	input  wire                          scan_en,
	input  wire [TIME_BITS-1:0]          now,
	input  wire [pps_pkg::ORD_W-1:0]     sub_cnt,
	input  wire                          in_hit,
	input  wire [IDX_W-1:0]              in_idx,
	input  wire [pps_pkg::PRIO_W-1:0]    in_prio,
	input  wire [TIME_BITS-1:0]          in_rel,
	input  wire [pps_pkg::ORD_W-1:0]     in_age,
	output logic                         out_hit,
	output logic [IDX_W-1:0]             out_idx,
	output logic [pps_pkg::PRIO_W-1:0]   out_prio,
	output logic [TIME_BITS-1:0]         out_rel,
	output logic [pps_pkg::ORD_W-1:0]    out_age,
	// service of the picked slot
	input  wire                          svc_en,
	input  wire                          svc_done,
	output logic                         valid,
	output logic [pps_pkg::ID_W-1:0]     id,
	output logic [TIME_BITS-1:0]         arr,
	output logic [pps_pkg::FIELD_W-1:0]  len,
	output logic [pps_pkg::FIELD_W-1:0]  left,
	output logic [TIME_BITS-1:0]         first
);
	logic rel_q, srv_q;
	logic [pps_pkg::PRIO_W-1:0] prio_q;
	logic [TIME_BITS-1:0] relt_q;
	logic [pps_pkg::ORD_W-1:0] ord_q;
	logic rel_now, ready, better;
	logic [TIME_BITS-1:0] my_rel;
	logic [pps_pkg::ORD_W-1:0] my_age;

	assign rel_now = valid && !rel_q && (arr <= now);
	assign ready = valid && (rel_q || rel_now);
	assign my_rel = rel_q ? relt_q : now;
	assign my_age = sub_cnt - ord_q;

	always_comb begin
		if (!in_hit) better = 1'b1;
		else if (prio_q != in_prio) better = prio_q < in_prio;
		else if (my_rel != in_rel) better = my_rel < in_rel;
		else better = my_age < in_age;
	end

	always_comb begin
		if (ready && better) begin
			out_hit = 1'b1;
			out_idx = my_idx;
			out_prio = prio_q;
			out_rel = my_rel;
			out_age = my_age;
		end else begin
			out_hit = in_hit;
			out_idx = in_idx;
			out_prio = in_prio;
			out_rel = in_rel;
			out_age = in_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
			rel_q <= 1'b0;
			srv_q <= 1'b0;
		end else if (wr_en) begin
			valid <= 1'b1;
			rel_q <= 1'b0;
			srv_q <= 1'b0;
		end else if (svc_en && svc_done) begin
			valid <= 1'b0;
			rel_q <= 1'b0;
			srv_q <= 1'b0;
		end else begin
			if (scan_en && rel_now) rel_q <= 1'b1;
			if (svc_en) srv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id <= wr_id;
			arr <= wr_arr;
			len <= wr_len;
			left <= wr_len;
			prio_q <= wr_prio;
			ord_q <= wr_ord;
		end else begin
			if (scan_en && rel_now) relt_q <= now;
			if (svc_en) begin
				left <= left - 1'b1;
				if (!srv_q) first <= now;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core: preemptive priority task scheduler
// Task table as a chain of slot cells, scanned one cell per cycle per tick.
// ----------------------------------------------------------------------------
// A submit transaction presents its result in the cycle after it is accepted.
// A tick transaction walks the cell chain one slot per cycle, then passes
// through a service state and an output state before its result appears.
// The next input is taken only once the result transaction is done, so a
// new input is never accepted while a transaction is in flight. One result
// transaction is produced per input transaction, held in an output register.
`default_nettype none
module preemptive_priority_scheduler_core #(
	parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// command[0], task_id[8:1], arrival_time[24:9], duration[40:25],
	// priority_req[48:41], zero fill up to bit 55
	input  wire [55:0]  s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// event_res[2:0], proc_id[10:3], finish_time[26:11], turnaround[42:27],
	// waiting[58:43], response[74:59], zero fill up to bit 79
	output logic [79:0] m_tdata
);
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SERV = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic                       hit;
		logic [IDX_W-1:0]           idx;
		logic [pps_pkg::PRIO_W-1:0] prio;
		logic [TIME_BITS-1:0]       rel;
		logic [pps_pkg::ORD_W-1:0]  age;
	} best_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	best_t best_q, best_n;
	logic [TIME_BITS-1:0] now_q;
	logic [pps_pkg::ORD_W-1:0] sub_q;
	logic [79:0] res_q;
	logic full_q;

	logic cmd;
	logic [pps_pkg::ID_W-1:0] in_id;
	logic [pps_pkg::FIELD_W-1:0] in_arr, in_dur;
	logic [pps_pkg::PRIO_W-1:0] in_prio;
	assign cmd = s_tdata[0];
	assign in_id = s_tdata[8:1];
	assign in_arr = s_tdata[24:9];
	assign in_dur = s_tdata[40:25];
	assign in_prio = s_tdata[48:41];

	logic [MAX_TASKS-1:0] v_w, wr_w, scan_w, svc_w;
	logic [pps_pkg::ID_W-1:0] id_w [MAX_TASKS];
	logic [TIME_BITS-1:0] arr_w [MAX_TASKS];
	logic [TIME_BITS-1:0] first_w [MAX_TASKS];
	logic [pps_pkg::FIELD_W-1:0] len_w [MAX_TASKS];
	logic [pps_pkg::FIELD_W-1:0] left_w [MAX_TASKS];
	best_t bo_w [MAX_TASKS];

	// lowest free slot
	logic free_any;
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!v_w[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	logic acc_in, do_submit, done_w, in_scan, in_serv;
	logic [IDX_W-1:0] scan_idx, pk;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign acc_in = s_tvalid && s_tready;
	assign do_submit = acc_in && (cmd == pps_pkg::CMD_SUBMIT) && free_any && (in_dur != '0);
	assign in_scan = state_q == ST_SCAN;
	assign in_serv = (state_q == ST_SERV) && best_q.hit;
	assign scan_idx = cnt_q[IDX_W-1:0];
	assign pk = best_q.idx;
	assign done_w = left_w[pk] == 16'd1;

	always_comb begin
		best_n = bo_w[scan_idx];
	end

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		assign wr_w[g] = do_submit && (free_idx == IDX_W'(g));
		assign scan_w[g] = in_scan && (scan_idx == IDX_W'(g));
		assign svc_w[g] = in_serv && (pk == IDX_W'(g));
		pps_cell #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .my_idx(IDX_W'(g)),
			.wr_en(wr_w[g]), .wr_id(in_id), .wr_arr(TIME_BITS'(in_arr)),
			.wr_len(in_dur), .wr_prio(in_prio), .wr_ord(sub_q),
			.scan_en(scan_w[g]), .now(now_q), .sub_cnt(sub_q),
			.in_hit(best_q.hit), .in_idx(best_q.idx), .in_prio(best_q.prio),
			.in_rel(best_q.rel), .in_age(best_q.age),
			.out_hit(bo_w[g].hit), .out_idx(bo_w[g].idx), .out_prio(bo_w[g].prio),
			.out_rel(bo_w[g].rel), .out_age(bo_w[g].age),
			.svc_en(svc_w[g]), .svc_done(done_w),
			.valid(v_w[g]), .id(id_w[g]), .arr(arr_w[g]), .len(len_w[g]),
			.left(left_w[g]), .first(first_w[g])
		);
	end

	// metrics of the completing task
	logic [TIME_BITS-1:0] fin, tat, rsp, frst;
	logic [TIME_BITS:0] wt_full;
	assign fin = (now_q == TMAX) ? now_q : now_q + 1'b1;
	assign tat = fin - arr_w[pk];
	assign wt_full = {1'b0, tat} - {1'b0, TIME_BITS'(len_w[pk])};
	assign frst = (left_w[pk] == len_w[pk]) ? now_q : first_w[pk];
	assign rsp = frst - arr_w[pk];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			best_q <= '0;
			now_q <= '0;
			sub_q <= '0;
			res_q <= '0;
			m_tvalid <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (cmd == pps_pkg::CMD_TICK) begin
							state_q <= ST_SCAN;
							cnt_q <= '0;
							best_q <= '0;
						end else begin
							m_tvalid <= 1'b1;
							res_q <= {77'd0, do_submit ? pps_pkg::EV_ACCEPT
								: pps_pkg::EV_REJECT};
							if (do_submit) sub_q <= sub_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					best_q <= best_n;
					if (cnt_q == CNT_W'(MAX_TASKS - 1)) state_q <= ST_SERV;
					cnt_q <= cnt_q + 1'b1;
				end
				ST_SERV: begin
					if (now_q != TMAX) now_q <= now_q + 1'b1;
					state_q <= ST_OUT;
					if (!best_q.hit) res_q <= {77'd0, pps_pkg::EV_IDLE};
					else if (done_w)
						res_q <= {5'd0, 16'(rsp), wt_full[TIME_BITS] ? 16'd0
							: 16'(wt_full[TIME_BITS-1:0]), 16'(tat), 16'(fin),
							id_w[pk], pps_pkg::EV_DONE};
					else res_q <= {69'd0, id_w[pk], pps_pkg::EV_RAN};
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			full_q <= &v_w;
		end
	end

	assign m_tdata = res_q;

	a_one_state: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("ready while busy");
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && &v_w) |-> !do_submit) else $error("submit into full table");
endmodule
`default_nettype wire
